>>> design/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants of the k-way merge unit.
// ----------------------------------------------------------------------------
package kwm_pkg;

    // Run count the unit is built for; source is 4 bits, so at most 16 are reachable.
    localparam int WAYS     = 16;
    localparam int CAP      = (WAYS < 16) ? WAYS : 16;
    localparam int IDX_W    = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CNT_W    = $clog2(CAP + 1);
    localparam int CFG_W    = 5;
    localparam int VAL_W    = 32;
    localparam int SRC_W    = 4;

    typedef struct packed {
        logic [SRC_W-1:0]        source;
        logic signed [VAL_W-1:0] value_in;
        logic                    run_done;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_out;
        logic [SRC_W-1:0]        refill_source;
        logic                    finished;
    } t_out_item;

endpackage

>>> design/k_way_merge_unit.sv
// ----------------------------------------------------------------------------
// k_way_merge_unit
// Merges up to 16 sorted runs with one head per run and a sequential min search.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item): each item is the next
//   element of run "source", or an end mark for that run (run_done = 1).
//   Output channel (o_out_valid / i_out_ready / o_out_item): once every run in
//   use holds a head or is exhausted, the least head goes out with its run
//   index (ties to the lowest index); the driver then feeds that run. When all
//   runs in use are exhausted, a finished item goes out instead.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_ways_in_use): number of
//   runs in use; 0 acts as 1, values above 16 clamp. Write only while idle.
// Sequence:
//   An item is taken in while idle; then a single signed comparator walks
//   the heads of the runs in use one by one (stopping early at the first run
//   that still lacks a head), a last scan step closes the walk and the emit
//   state loads the output register. Not ready meanwhile.
//   The output register holds the result while the receiver stalls; the next
//   item is taken in during that wait, and its own result waits for the
//   register to free up.
// Reset (i_rst_n low, synchronous): clears all head-present and exhausted
//   bits, sets ways_in_use to 16 and drops any pending output.
// ----------------------------------------------------------------------------
module k_way_merge_unit
    import kwm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_ways_in_use
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]              r_state;
    logic [CFG_W-1:0]        r_ways;
    logic [CAP-1:0]          r_present;
    logic [CAP-1:0]          r_exhausted;
    logic signed [VAL_W-1:0] r_heads [CAP];

    // scan state
    logic [CNT_W-1:0]        r_idx;
    logic                    r_found;
    logic                    r_all_done;
    logic [IDX_W-1:0]        r_best;
    logic signed [VAL_W-1:0] r_best_val;

    logic                    r_out_valid;
    t_out_item               r_out_item;

    logic [CFG_W-1:0]        w_eff;
    logic                    w_src_used;
    logic [IDX_W-1:0]        w_src_idx;
    logic [IDX_W-1:0]        w_scan_idx;
    logic                    w_scan_end;
    logic signed [VAL_W-1:0] w_head;
    logic                    w_less;
    logic                    w_out_free;

    // effective run count
    always_comb begin
        if (r_ways == '0) begin
            w_eff = CFG_W'(1);
        end else if (r_ways > CFG_W'(CAP)) begin
            w_eff = CFG_W'(CAP);
        end else begin
            w_eff = r_ways;
        end
    end

    assign w_src_used = (CFG_W'(i_in_item.source) < w_eff);
    assign w_src_idx  = IDX_W'(i_in_item.source);
    assign w_scan_idx = r_idx[IDX_W-1:0];
    assign w_scan_end = (CFG_W'(r_idx) >= w_eff);
    assign w_head     = r_heads[w_scan_idx];
    assign w_less     = (w_head < r_best_val);
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // head store: written on accepted elements only
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready && w_src_used && !i_in_item.run_done
            && !r_present[w_src_idx] && !r_exhausted[w_src_idx]) begin
            r_heads[w_src_idx] <= i_in_item.value_in;
        end
    end

    // scan payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && !w_scan_end && !r_exhausted[w_scan_idx]
            && r_present[w_scan_idx] && (!r_found || w_less)) begin
            r_best     <= w_scan_idx;
            r_best_val <= w_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ways      <= CFG_W'(16);
            r_present   <= '0;
            r_exhausted <= '0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_all_done  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_ways <= i_cfg_ways_in_use;
            end
            // a new result loads the register; otherwise a taken one leaves it
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (w_src_used) begin
                            if (i_in_item.run_done) begin
                                r_exhausted[w_src_idx] <= 1'b1;
                                r_present[w_src_idx]   <= 1'b0;
                            end else if (!r_exhausted[w_src_idx]) begin
                                r_present[w_src_idx] <= 1'b1;
                            end
                        end
                        r_idx      <= '0;
                        r_found    <= 1'b0;
                        r_all_done <= 1'b1;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_scan_end) begin
                        r_state <= S_EMIT;
                    end else if (r_exhausted[w_scan_idx]) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end else if (!r_present[w_scan_idx]) begin
                        // a run still lacks its head: no result
                        r_state <= S_IDLE;
                    end else begin
                        r_all_done <= 1'b0;
                        r_found    <= 1'b1;
                        r_idx      <= r_idx + CNT_W'(1);
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        if (!r_all_done) begin
                            r_present[r_best] <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_out_free) begin
            if (r_all_done) begin
                r_out_item.value_out     <= '0;
                r_out_item.refill_source <= '0;
                r_out_item.finished      <= 1'b1;
            end else begin
                r_out_item.value_out     <= r_best_val;
                r_out_item.refill_source <= SRC_W'(r_best);
                r_out_item.finished      <= 1'b0;
            end
        end
    end

endmodule

>>> sim/k_way_merge_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_merge_unit_tb
// Self-checking bench for the k-way merge unit. It feeds sorted runs the way a
// merge driver would, always refilling a run that lacks a head, and mixes in
// stray items, duplicates and end marks. A behavioral merge model built into
// the bench tracks the heads and predicts every merged item. The output
// stream is then checked item by item, in order. The run count register is
// swept through its extremes between phases. Both channels stall at random.
// ----------------------------------------------------------------------------
module k_way_merge_unit_tb;
    import kwm_pkg::*;

    localparam longint TAIL_MAX   = 64'sd2147483647;
    localparam int     IDLE_WAIT  = 40;         // well past the longest search
    localparam int     MAX_REPORT = 10;

    // DUT-facing signals, known from time zero
    logic             i_clk             = 1'b0;
    logic             i_rst_n           = 1'b0;
    logic             i_in_valid        = 1'b0;
    logic             o_in_ready;
    t_in_item         i_in_item         = '0;
    logic             o_out_valid;
    logic             i_out_ready       = 1'b0;
    t_out_item        o_out_item;
    logic             i_cfg_valid       = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_ways_in_use = '0;

    // Merge model state: one head per run plus held/ended flags
    logic signed [VAL_W-1:0] head_val [16];
    logic [15:0]             head_held;
    logic [15:0]             run_ended;
    logic [CFG_W-1:0]        ways_reg;

    // Last element handed to each run, so that runs stay ascending
    longint                  run_tail [16];

    t_out_item               sorted_stream_q [$];   // merged items still due
    t_out_item               due_item;
    int                      mismatch_cnt = 0;
    int                      ready_hold   = 0;
    bit                      gaps_on      = 1'b1;

    k_way_merge_unit DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_item         (i_in_item),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_item        (o_out_item),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_ways_in_use (i_cfg_ways_in_use)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Merge model
    // ------------------------------------------------------------------------

    // Runs actually in use: 0 acts as 1, anything above the build size clamps.
    function automatic int live_ways();
        int w;
        w = ways_reg;
        if (w < 1) w = 1;
        if (w > CAP) w = CAP;
        return w;
    endfunction

    // Applies one item to the head store, then looks for the least head.
    // Returns 1 when the item brings out a merged item (or a finished one).
    function automatic bit merge_predict(input t_in_item it, output t_out_item res);
        int                      w;
        int                      best;
        bit                      all_ready;
        bit                      none_live;
        logic signed [VAL_W-1:0] best_v;
        w         = live_ways();
        best      = -1;
        best_v    = '0;
        all_ready = 1'b1;
        none_live = 1'b1;
        res       = '0;
        if (it.source < w) begin
            if (it.run_done) begin
                // end mark: run closes for good, a held head is thrown away
                run_ended[it.source] = 1'b1;
                head_held[it.source] = 1'b0;
            end else if (!head_held[it.source] && !run_ended[it.source]) begin
                head_val[it.source]  = it.value_in;
                head_held[it.source] = 1'b1;
            end
        end
        // ties: strict less-than keeps the lowest run index
        for (int i = 0; i < w; i++) begin
            if (!run_ended[i]) begin
                none_live = 1'b0;
                if (!head_held[i]) begin
                    all_ready = 1'b0;
                    break;
                end
                if (best < 0 || head_val[i] < best_v) begin
                    best   = i;
                    best_v = head_val[i];
                end
            end
        end
        if (!all_ready) return 1'b0;
        if (none_live) begin
            res.finished = 1'b1;
            return 1'b1;
        end
        head_held[best]   = 1'b0;
        res.value_out     = best_v;
        res.refill_source = SRC_W'(best);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_in_item make_item(input int src, input logic signed [VAL_W-1:0] v,
                                           input logic done);
        t_in_item it;
        it.source   = SRC_W'(src);
        it.value_in = v;
        it.run_done = done;
        return it;
    endfunction

    // Next element of a run: equal to the last one now and then, mostly a
    // small step up, sometimes a big jump; saturates at the top of the range.
    function automatic logic signed [VAL_W-1:0] next_in_run(input int src);
        longint v;
        v = run_tail[src];
        case ($urandom_range(0, 7))
            0, 1: ;
            2: v = v + longint'($urandom_range(0, 32'h00FF_FFFF));
            default: v = v + longint'($urandom_range(1, 500));
        endcase
        if (v > TAIL_MAX) v = TAIL_MAX;
        run_tail[src] = v;
        return v[VAL_W-1:0];
    endfunction

    // A run in use that is still open and has no head: what the driver feeds.
    function automatic bit pick_hungry(output int src);
        int cands [$];
        src = 0;
        for (int i = 0; i < live_ways(); i++) begin
            if (!run_ended[i] && !head_held[i]) cands.push_back(i);
        end
        if (cands.size() == 0) return 1'b0;
        src = cands[$urandom_range(0, cands.size() - 1)];
        return 1'b1;
    endfunction

    function automatic bit all_runs_ended();
        for (int i = 0; i < live_ways(); i++) begin
            if (!run_ended[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Sends one item and logs what it should bring out. Valid is left high at
    // the accepting edge so that back-to-back items need no second NBA there.
    task automatic send_item(input t_in_item it);
        t_out_item res;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        if (merge_predict(it, res)) sorted_stream_q.push_back(res);
    endtask

    // Register write only once the block has gone quiet: every merged item
    // out, plus slack for an item still in the search with nothing to emit.
    task automatic write_ways(input logic [CFG_W-1:0] ways);
        i_in_valid <= 1'b0;
        while (sorted_stream_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_ways_in_use <= ways;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ways_reg     = ways;
    endtask

    // Driver loop: n well-formed refills, plus stray items at noise_pct.
    // end_pct > 0 lets runs close, both on refills and in the noise.
    task automatic feed_merge(input int n, input int noise_pct, input int end_pct);
        int       fed;
        int       src;
        bit       hungry;
        t_in_item it;
        fed = 0;
        while (fed < n && !all_runs_ended()) begin
            hungry = pick_hungry(src);
            if (!hungry || $urandom_range(0, 99) < noise_pct) begin
                // stray item: any run, any value; mostly dropped or ignored
                it = make_item($urandom_range(0, 15), $urandom,
                               (end_pct > 0) && ($urandom_range(0, 7) == 0));
            end else if (end_pct > 0 && $urandom_range(0, 99) < end_pct) begin
                it = make_item(src, $urandom, 1'b1);
                fed++;
            end else begin
                it = make_item(src, next_in_run(src), 1'b0);
                fed++;
            end
            send_item(it);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset run count is 16: the first merged item appears only once all 15
    // open runs hold a head (run 15 is closed empty first). Heads cover the
    // range ends and ties among runs 1, 2 and 11.
    task automatic test_reset_ways_and_extremes();
        logic signed [VAL_W-1:0] heads [15];
        heads = '{32'sh7FFF_FFFF, 5, 5, 32'sh8000_0000, -1, 0, 7, 32'sh7FFF_FFFF,
                  100, -100, 42, 5, 3, 9, -1};
        // empty run: its very first item is an end mark
        send_item(make_item(15, 32'sh5A5A_A5A5, 1'b1));
        for (int i = 0; i < 15; i++) begin
            send_item(make_item(i, heads[i], 1'b0));
            run_tail[i] = heads[i];
        end
        // run 0 already holds a head, so this element is dropped
        send_item(make_item(0, -7, 1'b0));
        // refill the most negative run with the same value again
        send_item(make_item(3, 32'sh8000_0000, 1'b0));
        feed_merge(4, 0, 0);
    endtask

    // Register extremes: 0 acts as a single run, 31 clamps to the full set.
    task automatic test_ways_register_extremes();
        write_ways(5'd0);
        // run 9 is not in use: nothing changes
        send_item(make_item(9, $urandom, 1'b0));
        feed_merge(2, 0, 0);
        write_ways(5'd31);
        feed_merge(2, 0, 0);
    endtask

    // Long merges at several run counts; heads carry over between settings.
    task automatic test_random_merge();
        logic [CFG_W-1:0] plan [7];
        plan    = '{5'd2, 5'd7, 5'd16, 5'd1, 5'd17, 5'd0, 5'd9};
        plan[6] = CFG_W'($urandom_range(3, 15));
        foreach (plan[p]) begin
            write_ways(plan[p]);
            feed_merge(175, 12, 0);
        end
    endtask

    // Last part, no stalls: close a run that still holds a head, let runs
    // run dry at random, then check that finished repeats after the end.
    task automatic test_run_exhaustion();
        gaps_on = 1'b0;
        write_ways(5'd16);
        for (int i = 0; i < 16; i++) begin
            if (head_held[i] && !run_ended[i]) begin
                send_item(make_item(i, $urandom, 1'b1));
                break;
            end
        end
        feed_merge(350, 10, 5);
        for (int i = 0; i < 16; i++) begin
            if (!run_ended[i]) send_item(make_item(i, $urandom, 1'b1));
        end
        // everything closed: each further item repeats the finished item
        send_item(make_item(0, 32'sh1234_5678, 1'b0));
        send_item(make_item(4, $urandom, 1'b1));
        write_ways(5'd3);
        send_item(make_item(9, $urandom, 1'b0));
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls and in-order checking
    // ------------------------------------------------------------------------

    // Ready drops at random while gaps are on, between stretches of ready.
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            ready_hold  <= $urandom_range(0, 14);
        end else begin
            i_out_ready <= 1'b1;
            ready_hold  <= $urandom_range(0, 19);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sorted_stream_q.size() == 0) begin
                if (mismatch_cnt < MAX_REPORT) begin
                    $display("unexpected item: value %0d run %0d finished %0b",
                             o_out_item.value_out, o_out_item.refill_source,
                             o_out_item.finished);
                end
                mismatch_cnt++;
            end else begin
                due_item = sorted_stream_q.pop_front();
                if (o_out_item.value_out !== due_item.value_out ||
                    o_out_item.refill_source !== due_item.refill_source ||
                    o_out_item.finished !== due_item.finished) begin
                    if (mismatch_cnt < MAX_REPORT) begin
                        $write("mismatch: expected value %0d run %0d finished %0b, ",
                               due_item.value_out, due_item.refill_source,
                               due_item.finished);
                        $display("got value %0d run %0d finished %0b",
                                 o_out_item.value_out, o_out_item.refill_source,
                                 o_out_item.finished);
                    end
                    mismatch_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        head_held = '0;
        run_ended = '0;
        ways_reg  = CFG_W'(16);
        foreach (head_val[i]) head_val[i] = '0;
        foreach (run_tail[i]) run_tail[i] = longint'($signed($urandom)) >>> 2;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_ways_and_extremes();
        test_ways_register_extremes();
        test_random_merge();
        test_run_exhaustion();

        i_in_valid <= 1'b0;
        while (sorted_stream_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hang guard: far beyond the slowest legal run
    initial begin
        #(5_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
